// ===== hw/rtl/lrd_pkg.sv =====
// Shared types and constants for the layer run-length decoder.
// Used by layer_rle_run_decoder_core and its port checker; no dependencies.
package lrd_pkg;

  // Field widths of the byte stream and of the decoded run.
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned LEN_W       = 28;
  localparam int unsigned ACCUM_W     = 24;
  localparam int unsigned NIBBLE_W    = 4;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned OUT_TDATA_W = 40;

  // Grey values forced by black and white tokens.
  localparam logic [DATA_W-1:0] VALUE_BLACK = 8'h00;
  localparam logic [DATA_W-1:0] VALUE_WHITE = 8'hff;

  // Token kinds, from head byte bits 7:6.
  typedef enum logic [1:0] {
    KIND_BLACK = 2'd0,
    KIND_GREY  = 2'd1,
    KIND_DELTA = 2'd2,
    KIND_WHITE = 2'd3
  } token_kind_t;

endpackage

// ===== hw/rtl/layer_rle_run_decoder_core.sv =====
// Layer run-length decoder: one encoded byte in per word, one decoded run out per token.
// Depends on lrd_pkg for field widths and token kind codes.
//
// Usage:
//   Input stream (s_axis_*): one encoded byte per word in tdata[7:0]; tuser is
//   the layer start flag, set on the first byte of a layer. That byte clears
//   the parser and the previous grey value and is taken as a head byte.
//   Output stream (m_axis_*): one word per completed token, grey value in
//   tdata[7:0] and run length in tdata[35:8]; tdata[39:36] read as zero.
//   A run length of zero is passed on like any other run.
// Timing:
//   A byte accepted from the input stream lands in the input register and is
//   parsed against the stored token state; the word of a completed token is
//   loaded from that parse into the result register once it can take a word.
//   One byte is taken per cycle for as long as the receiver keeps up; the
//   parse step is a handful of muxes and one 8-bit add or subtract.
// Stalls and reset:
//   When the receiver holds tready low with a word pending, the parse stage
//   stops and the input register holds one byte, after which s_axis_tready
//   drops. A token cut off mid-stream gives no word and is discarded by the
//   next layer start. Reset empties both registers and clears the parser.
module layer_rle_run_decoder_core
  import lrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] layer_start
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [7:0] pixel_value, [35:8] run_length
);

  // Input register
  logic              in_valid;
  logic [DATA_W-1:0] in_byte;
  logic              in_start;

  // Parser state
  logic [COUNT_W-1:0]  bytes_expected, bytes_expected_next;
  token_kind_t         token_kind, token_kind_next;
  logic [1:0]          length_form, length_form_next;
  logic [NIBBLE_W-1:0] head_nibble, head_nibble_next;
  logic [DATA_W-1:0]   current_value, current_value_next;
  logic [ACCUM_W-1:0]  run_accum, run_accum_next;
  logic                awaiting_grey, awaiting_grey_next;

  // Result register
  logic [DATA_W-1:0] pixel_value;
  logic [LEN_W-1:0]  run_length;

  // Parse step outputs
  logic              token_done;
  logic [DATA_W-1:0] result_value;
  logic [LEN_W-1:0]  result_length;

  logic out_free;
  logic advance;

  // The parse stage moves whenever the result register can take a word.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  // One byte of parsing: update token state and finish the token if complete.
  always_comb begin
    logic [COUNT_W-1:0]  be;
    logic [DATA_W-1:0]   cur;
    logic [ACCUM_W-1:0]  acc;
    logic                aw;
    logic [COUNT_W-1:0]  grey_extra;

    // A layer start clears the parser before the byte is taken.
    be  = in_start ? '0 : bytes_expected;
    cur = in_start ? '0 : current_value;
    acc = in_start ? '0 : run_accum;
    aw  = in_start ? 1'b0 : awaiting_grey;

    token_kind_next     = in_start ? KIND_BLACK : token_kind;
    length_form_next    = in_start ? 2'd0 : length_form;
    head_nibble_next    = in_start ? '0 : head_nibble;
    current_value_next  = cur;
    run_accum_next      = acc;
    awaiting_grey_next  = aw;
    bytes_expected_next = be;
    grey_extra          = '0;

    if (be == '0) begin
      // Head byte: kind, length form and low nibble.
      token_kind_next  = token_kind_t'(in_byte[7:6]);
      length_form_next = in_byte[5:4];
      head_nibble_next = in_byte[3:0];
      run_accum_next   = '0;
      if (token_kind_t'(in_byte[7:6]) == KIND_DELTA) begin
        bytes_expected_next = {{(COUNT_W-1){1'b0}}, in_byte[4]};
        awaiting_grey_next  = 1'b0;
      end else begin
        awaiting_grey_next  = (token_kind_t'(in_byte[7:6]) == KIND_GREY);
        grey_extra          = {{(COUNT_W-1){1'b0}}, awaiting_grey_next};
        bytes_expected_next = {1'b0, in_byte[5:4]} + grey_extra;
      end
    end else begin
      // Further byte: the explicit grey value, else a length byte.
      if (aw) begin
        current_value_next = in_byte;
        awaiting_grey_next = 1'b0;
      end else begin
        run_accum_next = {acc[ACCUM_W-DATA_W-1:0], in_byte};
      end
      bytes_expected_next = be - COUNT_W'(1);
    end

    token_done = (bytes_expected_next == '0);

    // Value and length of a completed token.
    if (token_kind_next == KIND_DELTA) begin
      result_length = length_form_next[0] ?
                      {{(LEN_W-DATA_W){1'b0}}, run_accum_next[DATA_W-1:0]} :
                      LEN_W'(1);
      if (length_form_next[1]) begin
        result_value = current_value_next - {{(DATA_W-NIBBLE_W){1'b0}}, head_nibble_next};
      end else begin
        result_value = current_value_next + {{(DATA_W-NIBBLE_W){1'b0}}, head_nibble_next};
      end
    end else begin
      result_length = {run_accum_next, head_nibble_next};
      case (token_kind_next)
        KIND_BLACK: result_value = VALUE_BLACK;
        KIND_WHITE: result_value = VALUE_WHITE;
        default:    result_value = current_value_next;
      endcase
    end

    if (token_done) begin
      current_value_next = result_value;
    end
  end

  // Parser state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected <= '0;
      token_kind     <= KIND_BLACK;
      length_form    <= '0;
      head_nibble    <= '0;
      current_value  <= '0;
      run_accum      <= '0;
      awaiting_grey  <= 1'b0;
    end else if (advance) begin
      bytes_expected <= bytes_expected_next;
      token_kind     <= token_kind_next;
      length_form    <= length_form_next;
      head_nibble    <= head_nibble_next;
      current_value  <= current_value_next;
      run_accum      <= run_accum_next;
      awaiting_grey  <= awaiting_grey_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= advance && token_done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && token_done) begin
      pixel_value <= result_value;
      run_length  <= result_length;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-LEN_W-DATA_W){1'b0}}, run_length, pixel_value};

endmodule

// ===== hw/rtl/lrd_checker.sv =====
// Port-level checks for layer_rle_run_decoder_core, attached by bind.
// Depends on lrd_pkg for stream widths.
module lrd_checker
  import lrd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [DATA_W-1:0]      s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result word stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // Reset leaves the output empty.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // With the result register empty the input side never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Padding above the run length reads as zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:LEN_W+DATA_W] == '0)
    else $error("nonzero padding in output word");

endmodule

bind layer_rle_run_decoder_core lrd_checker u_lrd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
